FILE: hdl/crcfb_pkg.sv
package crcfb_pkg;

  localparam int unsigned MaxPayloadDefault = 256;

  localparam logic [15:0] CrcPoly     = 16'h1021;
  localparam logic [15:0] CrcInit     = 16'h0000;
  localparam logic [15:0] HeaderExtra = 16'd3;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 8;

  typedef struct packed {
    logic [8:0] payload_count;
    logic [7:0] service_id;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } beat_t;

  typedef enum logic [5:0] {
    PhLenLo = 6'b000001,
    PhLenHi = 6'b000010,
    PhSid   = 6'b000100,
    PhData  = 6'b001000,
    PhCrcLo = 6'b010000,
    PhCrcHi = 6'b100000
  } phase_e;

  // crc-16/xmodem, one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: hdl/crcfb_in_stage.sv
module crcfb_in_stage
  import crcfb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  item_valid_o,
  output item_t item_o,
  input  logic  take_i
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: hdl/crcfb_framer.sv
module crcfb_framer
  import crcfb_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  input  item_t item_i,
  output logic  take_o,
  output logic  beat_valid_o,
  input  logic  beat_ready_i,
  output beat_t beat_o
);

  localparam int unsigned CntW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MaxPay = 16'(MAX_PAYLOAD);

  phase_e          phase_q, phase_d;
  logic [15:0]     crc_q, crc_d;
  logic [CntW-1:0] left_q, left_d;

  logic [15:0] cnt_ext;
  logic [15:0] cnt_sat;
  logic [15:0] frame_len;
  logic        emit;
  logic        fire;
  logic        track;

  // zero counts as one, large counts clip to the maximum
  assign cnt_ext = {7'b0, item_i.payload_count};

  always_comb begin
    priority if (cnt_ext == 16'd0) begin
      cnt_sat = 16'd1;
    end else if (cnt_ext > MaxPay) begin
      cnt_sat = MaxPay;
    end else begin
      cnt_sat = cnt_ext;
    end
  end

  assign frame_len = cnt_sat + HeaderExtra;

  always_comb begin
    emit                = 1'b0;
    track               = 1'b1;
    beat_o.frame_byte   = item_i.data_byte;
    beat_o.end_of_frame = 1'b0;
    phase_d             = phase_q;
    left_d              = left_q;
    take_o              = 1'b0;
    fire                = 1'b0;
    unique case (phase_q)
      PhLenLo: begin
        emit              = item_valid_i;
        beat_o.frame_byte = frame_len[7:0];
        fire              = emit && beat_ready_i;
        if (fire) begin
          phase_d = PhLenHi;
          left_d  = CntW'(cnt_sat);
        end
      end
      PhLenHi: begin
        emit              = item_valid_i;
        beat_o.frame_byte = frame_len[15:8];
        fire              = emit && beat_ready_i;
        if (fire) begin
          phase_d = PhSid;
        end
      end
      PhSid: begin
        emit              = item_valid_i;
        beat_o.frame_byte = item_i.service_id;
        fire              = emit && beat_ready_i;
        if (fire) begin
          phase_d = PhData;
        end
      end
      PhData: begin
        emit              = item_valid_i;
        beat_o.frame_byte = item_i.data_byte;
        fire              = emit && beat_ready_i;
        take_o            = fire;
        if (fire) begin
          left_d  = left_q - CntW'(1);
          phase_d = (left_q == CntW'(1)) ? PhCrcLo : PhData;
        end
      end
      PhCrcLo: begin
        emit              = 1'b1;
        track             = 1'b0;
        beat_o.frame_byte = crc_q[7:0];
        fire              = beat_ready_i;
        if (fire) begin
          phase_d = PhCrcHi;
        end
      end
      PhCrcHi: begin
        emit                = 1'b1;
        track               = 1'b0;
        beat_o.frame_byte   = crc_q[15:8];
        beat_o.end_of_frame = 1'b1;
        fire                = beat_ready_i;
        if (fire) begin
          phase_d = PhLenLo;
        end
      end
      default: begin
        phase_d = PhLenLo;
      end
    endcase
  end

  always_comb begin
    crc_d = crc_q;
    if (fire) begin
      if (track) begin
        crc_d = crc_byte(crc_q, beat_o.frame_byte);
      end else if (phase_q == PhCrcHi) begin
        crc_d = CrcInit;
      end
    end
  end

  assign beat_valid_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLenLo;
      crc_q   <= CrcInit;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      left_q  <= left_d;
    end
  end

endmodule

FILE: hdl/crcfb_out_stage.sv
module crcfb_out_stage
  import crcfb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  beat_valid_i,
  output logic  beat_ready_o,
  input  beat_t beat_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output beat_t out_o
);

  logic  valid_q, valid_d;
  beat_t beat_q;

  assign beat_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (beat_ready_o) begin
      valid_d = beat_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_valid_i && beat_ready_o) begin
      beat_q <= beat_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = beat_q;

endmodule

FILE: hdl/crc16_command_frame_builder.sv
// command frame builder with a crc-16/xmodem trailer
//
// slave side takes one payload byte per transaction; service id and payload
// count only matter on the first byte of a frame. master side gives the frame
// bytes: length low, length high (count plus 3), service id, payload bytes,
// crc low, crc high. tlast is set on the crc high byte only.
// a payload count of zero counts as one, a count above MAX_PAYLOAD is clipped.
//
// a byte accepted on the slave side goes through the input register and then
// the output register before it shows up on the master side. one byte per
// cycle in the middle of a frame while the receiver takes bytes; the first
// byte of a frame waits in the input register while the three header bytes
// go out first, and two crc bytes follow, so n payload bytes make n + 5 bytes.
// the input register takes a new byte while the output register waits, if it is empty.
// reset empties both registers and starts at a frame boundary.
// when the receiver stalls the output byte holds and, once the input register
// is full, s_axis_tready drops.
module crc16_command_frame_builder
  import crcfb_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // data_byte [7:0], service_id [15:8], payload_count [24:16], zero [31:25]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // frame_byte [7:0]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast
);

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  take;
  logic  beat_valid;
  logic  beat_ready;
  beat_t beat;
  beat_t out_beat;

  assign in_item.data_byte     = s_axis_tdata[7:0];
  assign in_item.service_id    = s_axis_tdata[15:8];
  assign in_item.payload_count = s_axis_tdata[24:16];

  crcfb_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (take)
  );

  crcfb_framer #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .beat_valid_o (beat_valid),
    .beat_ready_i (beat_ready),
    .beat_o       (beat)
  );

  crcfb_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (beat_valid),
    .beat_ready_o (beat_ready),
    .beat_i       (beat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (out_beat)
  );

  assign m_axis_tdata = out_beat.frame_byte;
  assign m_axis_tlast = out_beat.end_of_frame;

  // a byte leaves the input register only as it moves into the output register
  a_take_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> item_valid && beat_valid && beat_ready)
    else $error("payload byte consumed without an output transfer");

  // after the crc high byte the next frame starts with its header
  a_header_after_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_valid && beat_ready && beat.end_of_frame |=> !take)
    else $error("payload byte taken right after end of frame");

  // input back pressure only while a byte waits in the input register
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> item_valid)
    else $error("input stalled with empty input register");

endmodule
